/* rtl/udp_csum_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_csum_pkg
// Shared types, constants and the checksum fold for the IPv4/UDP checksum core.
// ----------------------------------------------------------------------------
package udp_csum_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_VERSION_IHL_TOS = 3'd0;
  localparam logic [2:0] REG_IDENT           = 3'd1;
  localparam logic [2:0] REG_FLAGS_FRAGMENT  = 3'd2;
  localparam logic [2:0] REG_TIME_TO_LIVE    = 3'd3;
  localparam logic [2:0] REG_PAD_SOURCE_PORT = 3'd4;
  localparam logic [2:0] REG_PAD_LENGTH      = 3'd5;

  // configuration reset values
  localparam logic [15:0] RST_VERSION_IHL_TOS = 16'h4500;
  localparam logic [15:0] RST_IDENT           = 16'h0000;
  localparam logic [15:0] RST_FLAGS_FRAGMENT  = 16'h0000;
  localparam logic [7:0]  RST_TIME_TO_LIVE    = 8'd64;
  localparam logic [15:0] RST_PAD_SOURCE_PORT = 16'd53;
  localparam logic [10:0] RST_PAD_LENGTH      = 11'd200;

  // bytes_valid codes (three is taken as a full word)
  localparam logic [1:0] BYTES_NONE = 2'd0;
  localparam logic [1:0] BYTES_ODD  = 2'd1;

  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
  localparam logic [16:0] MAX_PAYLOAD   = 17'd65507;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [15:0] IP_UDP_BYTES  = 16'd28;
  localparam logic [15:0] ODD_BYTE_MASK = 16'hFF00;

  typedef struct packed {
    logic [15:0] version_ihl_tos;
    logic [15:0] ident;
    logic [15:0] flags_fragment;
    logic [7:0]  time_to_live;
    logic [15:0] pad_source_port;
    logic [10:0] pad_length;
  } cfg_t;

  // per-packet totals handed from the accumulator at the last word
  typedef struct packed {
    logic [15:0] sum;
    logic [16:0] count;
    logic [17:0] addr_sum;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } pkt_t;

  // end-around carry fold of a raw one's-complement sum
  function automatic logic [15:0] csum_fold(input logic [19:0] raw);
    logic [16:0] f1;
    begin
      f1 = {1'b0, raw[15:0]} + {13'b0, raw[19:16]};
      csum_fold = f1[15:0] + {15'b0, f1[16]};
    end
  endfunction

endpackage

/* rtl/udp_ipv4_checksum_offload_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_ipv4_checksum_offload_core
// IPv4 header and UDP checksum generator for a streamed UDP payload.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries the payload as 16-bit words, earlier byte in
//   the high half. tuser marks the first word of a packet, whose addresses and
//   ports are captured; tlast marks the final word. bytes_valid gives 2 for a
//   full word, 1 for an odd final byte and 0 for an empty payload.
//   One request on m_axis follows each tlast word, with both checksums, the
//   UDP and IP lengths, and the padded / too_long flags in tuser.
//   Throughput: one word per cycle while s_axis_tready is high. m_axis_tvalid
//   rises after the snapshot taken as the last word is accepted, the length
//   stage and the checksum fold stage. Reset clears the running sum, byte
//   count, held addresses and ports and loads the configuration defaults.
//   Configuration is written via cfg_write / cfg_index / cfg_data; users must
//   write it only while no packet is in flight; the core does not enforce it.
//   When m_axis stalls, the three result stages fill and s_axis_tready drops
//   only once a result would have no stage left to move into.
// ----------------------------------------------------------------------------
module udp_ipv4_checksum_offload_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] payload_word, [17:16] bytes_valid, [49:18] source_address,
  // [81:50] dest_address, [97:82] source_port, [113:98] dest_port, [119:114] 0
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  // [0] first_word
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] ip_header_checksum, [31:16] udp_checksum, [47:32] udp_length,
  // [63:48] ip_total_length
  output logic [63:0]  m_axis_tdata,
  // [0] padded, [1] too_long
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  udp_csum_pkg::cfg_t cfg;
  udp_csum_pkg::pkt_t snap;
  logic               snap_valid;
  logic               snap_ready;
  logic [15:0]        ip_header_checksum;
  logic [15:0]        udp_checksum;
  logic [15:0]        udp_length;
  logic [15:0]        ip_total_length;
  logic               padded;
  logic               too_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.version_ihl_tos <= udp_csum_pkg::RST_VERSION_IHL_TOS;
      cfg.ident           <= udp_csum_pkg::RST_IDENT;
      cfg.flags_fragment  <= udp_csum_pkg::RST_FLAGS_FRAGMENT;
      cfg.time_to_live    <= udp_csum_pkg::RST_TIME_TO_LIVE;
      cfg.pad_source_port <= udp_csum_pkg::RST_PAD_SOURCE_PORT;
      cfg.pad_length      <= udp_csum_pkg::RST_PAD_LENGTH;
    end else if (cfg_write) begin
      case (cfg_index)
        udp_csum_pkg::REG_VERSION_IHL_TOS: cfg.version_ihl_tos <= cfg_data;
        udp_csum_pkg::REG_IDENT:           cfg.ident           <= cfg_data;
        udp_csum_pkg::REG_FLAGS_FRAGMENT:  cfg.flags_fragment  <= cfg_data;
        udp_csum_pkg::REG_TIME_TO_LIVE:    cfg.time_to_live    <= cfg_data[7:0];
        udp_csum_pkg::REG_PAD_SOURCE_PORT: cfg.pad_source_port <= cfg_data;
        udp_csum_pkg::REG_PAD_LENGTH:      cfg.pad_length      <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  udp_csum_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_first   (s_axis_tuser[0]),
    .in_word    (s_axis_tdata[15:0]),
    .in_bytes   (s_axis_tdata[17:16]),
    .in_last    (s_axis_tlast),
    .in_src     (s_axis_tdata[49:18]),
    .in_dst     (s_axis_tdata[81:50]),
    .in_sport   (s_axis_tdata[97:82]),
    .in_dport   (s_axis_tdata[113:98]),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  udp_csum_finish u_finish (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .snap_valid         (snap_valid),
    .snap_ready         (snap_ready),
    .snap               (snap),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .ip_header_checksum (ip_header_checksum),
    .udp_checksum       (udp_checksum),
    .udp_length         (udp_length),
    .ip_total_length    (ip_total_length),
    .padded             (padded),
    .too_long           (too_long)
  );

  assign m_axis_tdata = {ip_total_length, udp_length, udp_checksum, ip_header_checksum};
  assign m_axis_tuser = {too_long, padded};

endmodule

/* rtl/udp_csum_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_csum_accum
// Running payload sum, byte count and header capture; snapshot on last word.
// ----------------------------------------------------------------------------
module udp_csum_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_first,
  input  logic [15:0]          in_word,
  input  logic [1:0]           in_bytes,
  input  logic                 in_last,
  input  logic [31:0]          in_src,
  input  logic [31:0]          in_dst,
  input  logic [15:0]          in_sport,
  input  logic [15:0]          in_dport,
  input  logic                 snap_ready,
  output logic                 snap_valid,
  output udp_csum_pkg::pkt_t   snap
);

  logic [15:0] running_sum;
  logic [16:0] byte_count;
  logic [17:0] address_sum;
  logic [15:0] held_source_port;
  logic [15:0] held_dest_port;

  logic        accept;
  logic [15:0] word_masked;
  logic [1:0]  nbytes;
  logic [15:0] base_sum;
  logic [16:0] base_count;
  logic [16:0] sum_raw;
  logic [15:0] sum_next;
  logic [17:0] count_wide;
  logic [16:0] count_next;
  logic [17:0] addr_in;

  assign in_ready = !snap_valid || snap_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (in_bytes)
      udp_csum_pkg::BYTES_NONE: begin
        word_masked = 16'h0000;
        nbytes      = 2'd0;
      end
      udp_csum_pkg::BYTES_ODD: begin
        word_masked = in_word & udp_csum_pkg::ODD_BYTE_MASK;
        nbytes      = 2'd1;
      end
      default: begin
        word_masked = in_word;
        nbytes      = 2'd2;
      end
    endcase
  end

  // first word restarts the packet
  assign base_sum   = in_first ? 16'h0000 : running_sum;
  assign base_count = in_first ? 17'd0 : byte_count;

  assign sum_raw    = {1'b0, base_sum} + {1'b0, word_masked};
  assign sum_next   = udp_csum_pkg::csum_fold({3'b0, sum_raw});
  assign count_wide = {1'b0, base_count} + {16'b0, nbytes};
  assign count_next = count_wide[17] ? udp_csum_pkg::COUNT_MAX : count_wide[16:0];

  assign addr_in = {2'b0, in_src[31:16]} + {2'b0, in_src[15:0]}
                 + {2'b0, in_dst[31:16]} + {2'b0, in_dst[15:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= 16'h0000;
      byte_count       <= 17'd0;
      address_sum      <= 18'd0;
      held_source_port <= 16'h0000;
      held_dest_port   <= 16'h0000;
    end else if (accept) begin
      if (in_last) begin
        running_sum <= 16'h0000;
        byte_count  <= 17'd0;
      end else begin
        running_sum <= sum_next;
        byte_count  <= count_next;
      end
      if (in_first) begin
        address_sum      <= addr_in;
        held_source_port <= in_sport;
        held_dest_port   <= in_dport;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_ready) begin
      snap_valid <= accept && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      snap.sum         <= sum_next;
      snap.count       <= count_next;
      snap.addr_sum    <= in_first ? addr_in : address_sum;
      snap.source_port <= in_first ? in_sport : held_source_port;
      snap.dest_port   <= in_first ? in_dport : held_dest_port;
    end
  end

endmodule

/* rtl/udp_csum_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_csum_finish
// Length, padding and checksum completion in two registered stages.
// ----------------------------------------------------------------------------
module udp_csum_finish (
  input  logic                 clk,
  input  logic                 rst,
  input  udp_csum_pkg::cfg_t   cfg,
  input  logic                 snap_valid,
  output logic                 snap_ready,
  input  udp_csum_pkg::pkt_t   snap,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          ip_header_checksum,
  output logic [15:0]          udp_checksum,
  output logic [15:0]          udp_length,
  output logic [15:0]          ip_total_length,
  output logic                 padded,
  output logic                 too_long
);

  logic        out_free;
  logic        s2_valid;
  logic [15:0] s2_udp_len;
  logic [15:0] s2_ip_len;
  logic        s2_pad;
  logic        s2_long;
  logic [18:0] s2_ip_part;
  logic [18:0] s2_udp_part;

  logic        pad;
  logic [16:0] payload;
  logic        over;
  logic [15:0] payload_sat;
  logic [18:0] ip_part;
  logic [18:0] udp_part;
  logic [19:0] ip_raw;
  logic [19:0] udp_raw;

  assign out_free   = !out_valid || out_ready;
  assign snap_ready = !s2_valid || out_free;

  // stage 2: lengths and the length-independent partial sums
  assign pad = (snap.source_port == cfg.pad_source_port)
            && (snap.count < {6'b0, cfg.pad_length});
  assign payload     = pad ? {6'b0, cfg.pad_length} : snap.count;
  assign over        = payload > udp_csum_pkg::MAX_PAYLOAD;
  assign payload_sat = over ? udp_csum_pkg::MAX_PAYLOAD[15:0] : payload[15:0];

  assign ip_part = {3'b0, cfg.version_ihl_tos} + {3'b0, cfg.ident}
                 + {3'b0, cfg.flags_fragment}
                 + {3'b0, cfg.time_to_live, udp_csum_pkg::PROTO_UDP}
                 + {1'b0, snap.addr_sum};
  assign udp_part = {3'b0, snap.sum} + {3'b0, snap.source_port}
                  + {3'b0, snap.dest_port} + {11'b0, udp_csum_pkg::PROTO_UDP}
                  + {1'b0, snap.addr_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (snap_ready) begin
      s2_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      s2_udp_len  <= payload_sat + udp_csum_pkg::UDP_HDR_BYTES;
      s2_ip_len   <= payload_sat + udp_csum_pkg::IP_UDP_BYTES;
      s2_pad      <= pad;
      s2_long     <= over;
      s2_ip_part  <= ip_part;
      s2_udp_part <= udp_part;
    end
  end

  // stage 3: add length terms (UDP length counts twice), fold, complement
  assign ip_raw  = {1'b0, s2_ip_part} + {4'b0, s2_ip_len};
  assign udp_raw = {1'b0, s2_udp_part} + {3'b0, s2_udp_len, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      ip_header_checksum <= ~udp_csum_pkg::csum_fold(ip_raw);
      udp_checksum       <= ~udp_csum_pkg::csum_fold(udp_raw);
      udp_length         <= s2_udp_len;
      ip_total_length    <= s2_ip_len;
      padded             <= s2_pad;
      too_long           <= s2_long;
    end
  end

endmodule

/* sim/udp_ipv4_checksum_offload_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_ipv4_checksum_offload_core_tb
// Self-checking bench for the IPv4/UDP checksum core. Payload words are driven
// on s_axis with bursty pacing while m_axis stalls on its own schedule; a
// shadow accumulator computes both checksums, the lengths and the flags for
// every tlast word, and each result request is compared in order.
// ----------------------------------------------------------------------------
module udp_ipv4_checksum_offload_core_tb;

  localparam int LATENCY         = 2;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 265;
  localparam int MAX_REPORTS     = 10;

  localparam logic [1:0] BYTES_FULL     = 2'd2;
  localparam logic [1:0] BYTES_FULL_ALT = 2'd3;
  // indexes past the register file; writes there must be dropped
  localparam logic [2:0] REG_SPARE_A    = 3'd6;
  localparam logic [2:0] REG_SPARE_B    = 3'd7;

  typedef struct packed {
    logic        first;
    logic [15:0] word;
    logic [1:0]  nbytes;
    logic        last;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } payload_beat_t;

  typedef struct packed {
    logic [15:0] ip_csum;
    logic [15:0] udp_csum;
    logic [15:0] udp_len;
    logic [15:0] ip_len;
    logic        padded;
    logic        too_long;
  } csum_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_STRIDE, RX_SPARSE} rx_mode_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_write;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  udp_ipv4_checksum_offload_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the core's registers and accumulator
  udp_csum_pkg::cfg_t shadow_cfg;
  logic [15:0]  acc_sum;
  logic [16:0]  acc_bytes;
  logic [17:0]  addr_sum;
  logic [15:0]  held_sport;
  logic [15:0]  held_dport;
  csum_result_t awaited_csums[$];

  int error_count       = 0;
  int stalled_cycles    = 0;
  int hold_off_requests = 0;
  int burst_left        = 0;
  bit tx_steady         = 1'b0;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'b0, t[16]};
  endfunction

  task automatic csum_accumulate(input payload_beat_t b);
    logic [15:0]  w;
    logic [17:0]  cnt;
    logic [16:0]  payload;
    logic [15:0]  ulen;
    logic [15:0]  ilen;
    logic [15:0]  ip_s;
    logic [15:0]  udp_s;
    csum_result_t r;
    if (b.first) begin
      acc_sum    = '0;
      acc_bytes  = '0;
      addr_sum   = {2'b0, b.src[31:16]} + {2'b0, b.src[15:0]}
                 + {2'b0, b.dst[31:16]} + {2'b0, b.dst[15:0]};
      held_sport = b.sport;
      held_dport = b.dport;
    end
    case (b.nbytes)
      udp_csum_pkg::BYTES_NONE: begin
        w   = 16'h0000;
        cnt = {1'b0, acc_bytes};
      end
      udp_csum_pkg::BYTES_ODD: begin
        w   = b.word & udp_csum_pkg::ODD_BYTE_MASK;
        cnt = {1'b0, acc_bytes} + 18'd1;
      end
      default: begin
        w   = b.word;
        cnt = {1'b0, acc_bytes} + 18'd2;
      end
    endcase
    acc_sum = oc_add(acc_sum, w);
    if (cnt > {1'b0, udp_csum_pkg::COUNT_MAX}) cnt = {1'b0, udp_csum_pkg::COUNT_MAX};
    acc_bytes = cnt[16:0];
    if (b.last) begin
      payload  = acc_bytes;
      r.padded = (held_sport == shadow_cfg.pad_source_port) &&
                 (payload < {6'b0, shadow_cfg.pad_length});
      if (r.padded) payload = {6'b0, shadow_cfg.pad_length};
      r.too_long = payload > udp_csum_pkg::MAX_PAYLOAD;
      if (r.too_long) payload = udp_csum_pkg::MAX_PAYLOAD;
      ulen = payload[15:0] + udp_csum_pkg::UDP_HDR_BYTES;
      ilen = payload[15:0] + udp_csum_pkg::IP_UDP_BYTES;

      ip_s = oc_add(shadow_cfg.version_ihl_tos, ilen);
      ip_s = oc_add(ip_s, shadow_cfg.ident);
      ip_s = oc_add(ip_s, shadow_cfg.flags_fragment);
      ip_s = oc_add(ip_s, {shadow_cfg.time_to_live, udp_csum_pkg::PROTO_UDP});
      ip_s = oc_add(ip_s, addr_sum[15:0]);
      ip_s = oc_add(ip_s, {14'b0, addr_sum[17:16]});

      udp_s = oc_add(acc_sum, held_sport);
      udp_s = oc_add(udp_s, held_dport);
      udp_s = oc_add(udp_s, ulen);
      udp_s = oc_add(udp_s, ulen);
      udp_s = oc_add(udp_s, {8'b0, udp_csum_pkg::PROTO_UDP});
      udp_s = oc_add(udp_s, addr_sum[15:0]);
      udp_s = oc_add(udp_s, {14'b0, addr_sum[17:16]});

      r.ip_csum  = ~ip_s;
      r.udp_csum = ~udp_s;
      r.udp_len  = ulen;
      r.ip_len   = ilen;
      awaited_csums.push_back(r);
      acc_sum   = '0;
      acc_bytes = '0;
    end
  endtask

  function automatic payload_beat_t make_beat(input logic first, input logic [15:0] word,
                                              input logic [1:0] nbytes, input logic last,
                                              input logic [31:0] src, input logic [31:0] dst,
                                              input logic [15:0] sport,
                                              input logic [15:0] dport);
    payload_beat_t b;
    b.first  = first;
    b.word   = word;
    b.nbytes = nbytes;
    b.last   = last;
    b.src    = src;
    b.dst    = dst;
    b.sport  = sport;
    b.dport  = dport;
    return b;
  endfunction

  function automatic payload_beat_t random_beat();
    return make_beat(1'b0, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)), 1'b0,
                     $urandom, $urandom, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
  endfunction

  // one request on s_axis; tvalid stays up across back-to-back words
  task automatic send_word(input payload_beat_t b);
    int gap;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          @(negedge clk);
          s_axis_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, b.dport, b.sport, b.dst, b.src, b.nbytes, b.word};
    s_axis_tlast  <= b.last;
    s_axis_tuser  <= b.first;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    csum_accumulate(b);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited_csums.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      udp_csum_pkg::REG_VERSION_IHL_TOS: shadow_cfg.version_ihl_tos = data;
      udp_csum_pkg::REG_IDENT:           shadow_cfg.ident           = data;
      udp_csum_pkg::REG_FLAGS_FRAGMENT:  shadow_cfg.flags_fragment  = data;
      udp_csum_pkg::REG_TIME_TO_LIVE:    shadow_cfg.time_to_live    = data[7:0];
      udp_csum_pkg::REG_PAD_SOURCE_PORT: shadow_cfg.pad_source_port = data;
      udp_csum_pkg::REG_PAD_LENGTH:      shadow_cfg.pad_length      = data[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [15:0] vit, input logic [15:0] ident,
                                input logic [15:0] flags, input logic [15:0] ttl,
                                input logic [15:0] pad_port, input logic [15:0] pad_len);
    write_reg(udp_csum_pkg::REG_VERSION_IHL_TOS, vit);
    write_reg(udp_csum_pkg::REG_IDENT, ident);
    write_reg(udp_csum_pkg::REG_FLAGS_FRAGMENT, flags);
    write_reg(udp_csum_pkg::REG_TIME_TO_LIVE, ttl);
    write_reg(udp_csum_pkg::REG_PAD_SOURCE_PORT, pad_port);
    write_reg(udp_csum_pkg::REG_PAD_LENGTH, pad_len);
  endtask

  // ---- tests ---------------------------------------------------------------

  task automatic test_directed();
    logic [31:0] s;
    logic [31:0] d;
    s = $urandom;
    d = $urandom;
    // no first word since reset: held addresses and ports are zero
    send_word(make_beat(1'b0, 16'h1234, BYTES_FULL, 1'b0, s, d, 16'h1111, 16'h2222));
    send_word(make_beat(1'b0, 16'hABCD, udp_csum_pkg::BYTES_ODD, 1'b1, s, d,
                        16'h3333, 16'h4444));
    // all ones everywhere
    send_word(make_beat(1'b1, 16'hFFFF, BYTES_FULL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        16'hFFFF, 16'hFFFF));
    // empty payload, all zero
    send_word(make_beat(1'b1, 16'h0000, udp_csum_pkg::BYTES_NONE, 1'b1, 32'h0, 32'h0,
                        16'h0, 16'h0));
    // odd byte mid-packet, then a three-byte-valid code
    send_word(make_beat(1'b1, 16'h5A5A, udp_csum_pkg::BYTES_ODD, 1'b0, s, d,
                        16'd4000, 16'd80));
    send_word(make_beat(1'b0, 16'hFFFF, BYTES_FULL_ALT, 1'b0, d, s, 16'd1, 16'd2));
    send_word(make_beat(1'b0, 16'h00FF, BYTES_FULL, 1'b1, d, s, 16'd3, 16'd4));
    // short packet from the padding port
    send_word(make_beat(1'b1, 16'h0102, BYTES_FULL, 1'b0, s, d,
                        udp_csum_pkg::RST_PAD_SOURCE_PORT, 16'd999));
    send_word(make_beat(1'b0, 16'h0304, udp_csum_pkg::BYTES_ODD, 1'b1, s, d,
                        16'd7, 16'd7));
    // restart in the middle of a packet
    send_word(make_beat(1'b1, 16'hDEAD, BYTES_FULL, 1'b0, 32'hC0A8_0001, 32'h0A00_0001,
                        16'd5000, 16'd6000));
    send_word(make_beat(1'b1, 16'hBEEF, BYTES_FULL, 1'b1, 32'hC0A8_0102, 32'h0A00_0203,
                        16'd5001, 16'd6001));
    // after last with no first: addresses stay held
    send_word(make_beat(1'b0, 16'h8000, BYTES_FULL, 1'b1, s, d, 16'hAAAA, 16'h5555));
    // empty word that is not last
    send_word(make_beat(1'b1, 16'hFFFF, udp_csum_pkg::BYTES_NONE, 1'b0, d, d,
                        16'd53, 16'd53));
    send_word(make_beat(1'b0, 16'hFFFF, BYTES_FULL, 1'b1, s, s, 16'd0, 16'd0));
    // carries through the running sum
    send_word(make_beat(1'b1, 16'hFFFF, BYTES_FULL, 1'b0, 32'hFFFF_0001, 32'h0001_FFFF,
                        16'hFFFE, 16'h0001));
    send_word(make_beat(1'b0, 16'hFFFF, BYTES_FULL, 1'b0, s, d, 16'h0, 16'h0));
    send_word(make_beat(1'b0, 16'hFFFF, BYTES_FULL, 1'b0, s, d, 16'h0, 16'h0));
    send_word(make_beat(1'b0, 16'hFF01, udp_csum_pkg::BYTES_ODD, 1'b1, s, d,
                        16'h0, 16'h0));
    drain_results();
  endtask

  task automatic test_config_extremes();
    write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
    // pad length 2047 from the all-ones port
    send_word(make_beat(1'b1, 16'h1357, BYTES_FULL, 1'b0, $urandom, $urandom,
                        16'hFFFF, 16'h0035));
    send_word(make_beat(1'b0, 16'h2468, BYTES_FULL, 1'b1, 32'h0, 32'h0, 16'h0, 16'h0));
    send_word(make_beat(1'b1, 16'h1357, BYTES_FULL, 1'b1, $urandom, $urandom,
                        16'hFFFE, 16'hFFFF));
    drain_results();

    write_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(make_beat(1'b1, 16'h0000, udp_csum_pkg::BYTES_NONE, 1'b1, 32'h0, 32'h0,
                        16'h0, 16'h0));
    send_word(make_beat(1'b1, 16'h00FF, udp_csum_pkg::BYTES_ODD, 1'b1, $urandom, 32'h0,
                        16'h0, 16'h1));
    drain_results();

    // upper data bits set on the narrow registers
    write_all_regs(udp_csum_pkg::RST_VERSION_IHL_TOS, 16'h1234, 16'h4000, 16'hAB40,
                   16'd8080, 16'hF5C0);
    send_word(make_beat(1'b1, 16'hCAFE, BYTES_FULL, 1'b0, $urandom, $urandom,
                        16'd8080, 16'd53));
    send_word(make_beat(1'b0, 16'hF00D, udp_csum_pkg::BYTES_ODD, 1'b1, 32'h0, 32'h0,
                        16'h0, 16'h0));
    drain_results();
  endtask

  task automatic test_backpressure();
    payload_beat_t b;
    hold_off_requests++;
    tx_steady = 1'b1;
    for (int i = 0; i < 40; i++) begin
      b = random_beat();
      b.first = 1'b1;
      b.last  = 1'b1;
      send_word(b);
    end
    tx_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    payload_beat_t b;
    int            kind;
    int            len;
    int            sent;
    logic [15:0]   sport;
    logic [15:0]   pad_len;
    for (int phase = 0; phase < 4; phase++) begin
      pad_len = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 48))
                                            : 16'($urandom_range(0, 2047));
      pad_len[15:11] = 5'($urandom_range(0, 31));
      write_all_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), pad_len);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // kind 0: no first word, kind 1: restart mid-packet, else well formed
        kind  = $urandom_range(0, 9);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 160)
                                            : $urandom_range(1, 12);
        sport = ($urandom_range(0, 1) != 0) ? shadow_cfg.pad_source_port
                                            : 16'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++) begin
          b = random_beat();
          b.first = ((kind != 0) && (i == 0)) || ((kind == 1) && (i == len / 2));
          b.last  = (i == len - 1);
          if (b.first) b.sport = sport;
          if (!b.last && $urandom_range(0, 7) != 0) b.nbytes = BYTES_FULL;
          send_word(b);
        end
        sent += len;
      end
      drain_results();
    end
  endtask

  // ---- receiver pacing -----------------------------------------------------

  initial begin : rx_pacing
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       served;
    int       tick;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    served    = 0;
    tick      = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_off_requests) begin
        served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_STRIDE: m_axis_tready <= (tick % 5) != 0;
          default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---- result check --------------------------------------------------------

  always @(posedge clk) begin : result_check
    csum_result_t got;
    csum_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ip_csum  = m_axis_tdata[15:0];
      got.udp_csum = m_axis_tdata[31:16];
      got.udp_len  = m_axis_tdata[47:32];
      got.ip_len   = m_axis_tdata[63:48];
      got.padded   = m_axis_tuser[0];
      got.too_long = m_axis_tuser[1];
      if (awaited_csums.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none pending: ip %h udp %h ulen %0d iplen %0d %s",
                   $realtime, got.ip_csum, got.udp_csum, got.udp_len, got.ip_len,
                   $sformatf("pad %b long %b", got.padded, got.too_long));
      end else begin
        want = awaited_csums.pop_front();
        if (got.ip_csum !== want.ip_csum || got.udp_csum !== want.udp_csum ||
            got.udp_len !== want.udp_len || got.ip_len !== want.ip_len ||
            got.padded !== want.padded || got.too_long !== want.too_long) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch", $realtime);
            $display("  exp: ip %h udp %h ulen %0d iplen %0d pad %b long %b",
                     want.ip_csum, want.udp_csum, want.udp_len, want.ip_len,
                     want.padded, want.too_long);
            $display("  got: ip %h udp %h ulen %0d iplen %0d pad %b long %b",
                     got.ip_csum, got.udp_csum, got.udp_len, got.ip_len,
                     got.padded, got.too_long);
          end
        end
      end
    end
  end

  // no request on either side for too long means the core is hung
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = '0;
    cfg_write     = 1'b0;
    cfg_index     = udp_csum_pkg::REG_VERSION_IHL_TOS;
    cfg_data      = '0;
    shadow_cfg.version_ihl_tos = udp_csum_pkg::RST_VERSION_IHL_TOS;
    shadow_cfg.ident           = udp_csum_pkg::RST_IDENT;
    shadow_cfg.flags_fragment  = udp_csum_pkg::RST_FLAGS_FRAGMENT;
    shadow_cfg.time_to_live    = udp_csum_pkg::RST_TIME_TO_LIVE;
    shadow_cfg.pad_source_port = udp_csum_pkg::RST_PAD_SOURCE_PORT;
    shadow_cfg.pad_length      = udp_csum_pkg::RST_PAD_LENGTH;
    acc_sum    = '0;
    acc_bytes  = '0;
    addr_sum   = '0;
    held_sport = '0;
    held_dport = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    drain_results();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
